@@ rtl/first_fit_cell_allocator_defines.svh @@
// ---------------------------------------------------------------------------
// First-fit cell allocator assertion macros
// Shared concurrent assertion shorthands, clocked by clk_i, reset by rst_ni.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_CELL_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_CELL_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define FFCA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FFCA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ffca_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffca_pkg
// Sizes, codes and shared types of the first-fit cell allocator.
// ---------------------------------------------------------------------------
package ffca_pkg;

  localparam int unsigned MAX_CELLS   = 128;
  localparam int unsigned HANDLE_BITS = 16;

  localparam int unsigned IDX_W    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int unsigned CNT_W    = $clog2(MAX_CELLS + 1);
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned POOL_W   = 8;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 2;

  localparam int unsigned HANDLE_LIMIT_I =
    (HANDLE_BITS >= 16) ? 65535 : ((1 << HANDLE_BITS) - 1);
  localparam logic [HANDLE_W-1:0] HANDLE_LIMIT = HANDLE_W'(HANDLE_LIMIT_I);

  localparam logic [POOL_W-1:0] POOL_RESET = POOL_W'(128);

  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_ERASE  = 2'd1;
  localparam logic [OP_W-1:0] OP_DEFRAG = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ERR  = 2'd2;

  typedef struct packed {
    logic                re;
    logic [IDX_W-1:0]    raddr;
    logic                we;
    logic [IDX_W-1:0]    waddr;
    logic [HANDLE_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle;
  } result_t;

endpackage

@@ rtl/first_fit_cell_allocator.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// first_fit_cell_allocator
// Pool cell allocator: first-fit allocate, erase by handle, compaction.
// ---------------------------------------------------------------------------
// Command words enter on in_valid_i/in_stall_o (opcode_i, size_or_handle_i);
// each returns one result word (status_o, handle_o) on out_valid_o/out_stall_i
// through an output register. pool_cells is to be written on
// cfg_valid_i/cfg_ready_o only while the block idles; the block does not
// enforce this. One command is in flight at a time; the map is swept one
// cell per cycle. Allocate searches, then writes back the run; erase sweeps
// the map; defragment packs, then zeroes the tail. Rejected commands
// (size zero, oversize, handle 0, handles used up) go straight to the result.
// The next command is taken in the cycle after the result is registered.
// After reset every cell reads free at once through per-cell valid flags;
// no clearing pass is run. pool_cells resets to 128. A stalled result
// blocks the next result, which waits in the sequencer and holds off input.
// ---------------------------------------------------------------------------
module first_fit_cell_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ffca_pkg::OP_W-1:0]     opcode_i,
  input  logic [ffca_pkg::HANDLE_W-1:0] size_or_handle_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ffca_pkg::STATUS_W-1:0] status_o,
  output logic [ffca_pkg::HANDLE_W-1:0] handle_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ffca_pkg::POOL_W-1:0]   cfg_pool_cells_i
);
  import ffca_pkg::*;

  logic [POOL_W-1:0]   pool_cells_q;
  mem_req_t            mem_req;
  logic [HANDLE_W-1:0] mem_rdata;
  logic                res_valid;
  result_t             res;
  logic                res_take;
  logic                out_valid_q;
  result_t             out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_cells_q <= POOL_RESET;
    end else if (cfg_valid_i) begin
      pool_cells_q <= cfg_pool_cells_i;
    end
  end

  ffca_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .arg_i        (size_or_handle_i),
    .pool_cells_i (pool_cells_q),
    .mem_req_o    (mem_req),
    .mem_rdata_i  (mem_rdata),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_take_i   (res_take)
  );

  ffca_map u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
      out_q       <= res;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_q.status;
  assign handle_o    = out_q.handle;

endmodule

@@ rtl/ffca_map.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffca_map
// Cell owner map: one read and one write port, registered read data.
// Per-entry valid flags make unwritten cells read as free after reset.
// ---------------------------------------------------------------------------
module ffca_map (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ffca_pkg::mem_req_t           req_i,
  output logic [ffca_pkg::HANDLE_W-1:0] rdata_o
);
  import ffca_pkg::*;

  logic [HANDLE_W-1:0] mem_q [MAX_CELLS];
  logic [MAX_CELLS-1:0] vld_q;
  logic [HANDLE_W-1:0] rdata_q;
  logic                rvld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rvld_q <= vld_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

@@ rtl/ffca_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffca_ctrl
// Command sequencer: streams the map one cell per cycle for first-fit
// search, erase and compaction, and writes back through the map port.
// ---------------------------------------------------------------------------
`include "first_fit_cell_allocator_defines.svh"

module ffca_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ffca_pkg::OP_W-1:0]     opcode_i,
  input  logic [ffca_pkg::HANDLE_W-1:0] arg_i,
  input  logic [ffca_pkg::POOL_W-1:0]   pool_cells_i,
  output ffca_pkg::mem_req_t            mem_req_o,
  input  logic [ffca_pkg::HANDLE_W-1:0] mem_rdata_i,
  output logic                          res_valid_o,
  output ffca_pkg::result_t             res_o,
  input  logic                          res_take_i
);
  import ffca_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_ALLOC, S_FILL, S_ERASE, S_DEFRAG, S_ZERO, S_DONE
  } state_e;

  state_e              state_q;
  logic [CNT_W-1:0]    addr_q;
  logic                pend_q;
  logic [IDX_W-1:0]    pidx_q;
  logic [CNT_W-1:0]    run_q;
  logic [CNT_W-1:0]    wr_q;
  logic [IDX_W-1:0]    end_q;
  logic [HANDLE_W-1:0] arg_q;
  logic                found_q;
  logic [HANDLE_W-1:0] last_handle_q;
  result_t             res_q;

  logic [CNT_W-1:0] size;
  logic             scanning;
  logic             issue;
  logic             scan_end;
  logic [CNT_W-1:0] run_nx;
  logic             hit;
  logic [CNT_W-1:0] first;
  mem_req_t         req;

  always_comb begin
    if (32'(pool_cells_i) > 32'(MAX_CELLS)) begin
      size = CNT_W'(MAX_CELLS);
    end else begin
      size = CNT_W'(pool_cells_i);
    end
  end

  assign scanning = (state_q == S_ALLOC) || (state_q == S_ERASE) || (state_q == S_DEFRAG);
  assign issue    = scanning && (addr_q < size);
  assign scan_end = !pend_q && (addr_q >= size);
  assign run_nx   = (mem_rdata_i == '0) ? run_q + CNT_W'(1) : '0;
  assign hit      = pend_q && (run_nx == arg_q[CNT_W-1:0]);
  assign first    = CNT_W'(pidx_q) + CNT_W'(1) - arg_q[CNT_W-1:0];

  always_comb begin
    req       = '0;
    req.re    = issue;
    req.raddr = addr_q[IDX_W-1:0];
    unique case (state_q)
      S_FILL: begin
        req.we    = 1'b1;
        req.waddr = wr_q[IDX_W-1:0];
        req.wdata = last_handle_q;
      end
      S_ERASE: begin
        req.we    = pend_q && (mem_rdata_i == arg_q);
        req.waddr = pidx_q;
      end
      S_DEFRAG: begin
        req.we    = pend_q && (mem_rdata_i != '0);
        req.waddr = wr_q[IDX_W-1:0];
        req.wdata = mem_rdata_i;
      end
      S_ZERO: begin
        req.we    = wr_q < size;
        req.waddr = wr_q[IDX_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      addr_q        <= '0;
      pend_q        <= 1'b0;
      pidx_q        <= '0;
      run_q         <= '0;
      wr_q          <= '0;
      end_q         <= '0;
      arg_q         <= '0;
      found_q       <= 1'b0;
      last_handle_q <= '0;
      res_q         <= '0;
    end else begin
      if (scanning) begin
        if (issue) begin
          addr_q <= addr_q + CNT_W'(1);
          pend_q <= 1'b1;
          pidx_q <= addr_q[IDX_W-1:0];
        end else begin
          pend_q <= 1'b0;
        end
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            addr_q       <= '0;
            pend_q       <= 1'b0;
            run_q        <= '0;
            wr_q         <= '0;
            found_q      <= 1'b0;
            arg_q        <= arg_i;
            res_q.handle <= '0;
            unique case (opcode_i)
              OP_ALLOC: begin
                if (arg_i == '0 || 32'(arg_i) > 32'(size) ||
                    last_handle_q >= HANDLE_LIMIT) begin
                  res_q.status <= ST_NULL;
                  state_q      <= S_DONE;
                end else begin
                  state_q <= S_ALLOC;
                end
              end
              OP_ERASE: begin
                if (arg_i == '0) begin
                  res_q.status <= ST_ERR;
                  state_q      <= S_DONE;
                end else begin
                  state_q <= S_ERASE;
                end
              end
              default: state_q <= S_DEFRAG;
            endcase
          end
        end
        S_ALLOC: begin
          if (pend_q) begin
            run_q <= run_nx;
          end
          if (hit) begin
            wr_q          <= first;
            end_q         <= pidx_q;
            last_handle_q <= last_handle_q + HANDLE_W'(1);
            state_q       <= S_FILL;
          end else if (scan_end) begin
            res_q.status <= ST_NULL;
            state_q      <= S_DONE;
          end
        end
        S_FILL: begin
          wr_q <= wr_q + CNT_W'(1);
          if (wr_q[IDX_W-1:0] == end_q) begin
            res_q.status <= ST_OK;
            res_q.handle <= last_handle_q;
            state_q      <= S_DONE;
          end
        end
        S_ERASE: begin
          if (req.we) begin
            found_q <= 1'b1;
          end
          if (scan_end) begin
            res_q.status <= found_q ? ST_OK : ST_ERR;
            state_q      <= S_DONE;
          end
        end
        S_DEFRAG: begin
          if (req.we) begin
            wr_q <= wr_q + CNT_W'(1);
          end
          if (scan_end) begin
            state_q <= S_ZERO;
          end
        end
        S_ZERO: begin
          if (wr_q < size) begin
            wr_q <= wr_q + CNT_W'(1);
          end else begin
            res_q.status <= ST_OK;
            state_q      <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_take_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign mem_req_o   = req;
  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  `FFCA_ASSERT_IMP(a_no_rw_clash, req.re && req.we, req.raddr != req.waddr, "map read/write clash")
  `FFCA_ASSERT_IMP(a_wr_in_pool, req.we, CNT_W'(req.waddr) < size, "map write beyond pool")
  `FFCA_ASSERT_IMP(a_handle_last, (state_q == S_DONE) && (res_q.handle != '0),
                   (res_q.status == ST_OK) && (res_q.handle == last_handle_q),
                   "result handle is not the last handle")
  `FFCA_ASSERT_NXT(a_busy_after_accept, in_valid_i && (state_q == S_IDLE),
                   state_q != S_IDLE, "no command in flight after accept")

endmodule

@@ tb/first_fit_cell_allocator_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// first_fit_cell_allocator_tb
// Self-checking bench for the first-fit cell allocator. A shadow copy of the
// cell map predicts every allocate, erase and compaction. Each result word is
// checked against the oldest prediction. Directed corner commands come
// first, then random command mixes over several pool sizes with random idle
// and stall on both sides. A short tail runs on a one-cell pool, then on the full map again.
// ---------------------------------------------------------------------------
module first_fit_cell_allocator_tb;
  import ffca_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;  // unused code, behaves as defrag
  localparam int STUCK_LIMIT  = 4000;
  localparam int PHASE_WORDS  = 200;
  localparam int PHASES       = 8;
  localparam int SETTLE       = 2 * MAX_CELLS + 40;

  class cell_map_tracker;
    logic [HANDLE_W-1:0] owner [MAX_CELLS];
    logic [HANDLE_W-1:0] last_handle;
    logic [POOL_W-1:0]   pool_cells;
    result_t             owed [$];
    int unsigned         mismatches;
    int unsigned         n_cmds, n_grant, n_null, n_reject, n_compact, n_checked;

    function new();
      int i;
      for (i = 0; i < MAX_CELLS; i++) owner[i] = '0;
      last_handle = '0;
      pool_cells  = POOL_RESET;
      mismatches  = 0;
      n_cmds = 0; n_grant = 0; n_null = 0; n_reject = 0; n_compact = 0; n_checked = 0;
    endfunction

    function int unsigned active_cells();
      return (pool_cells > MAX_CELLS) ? MAX_CELLS : int'(pool_cells);
    endfunction

    function result_t grant_run(logic [HANDLE_W-1:0] want);
      result_t r;
      int i, j, run, n;
      r.status = ST_NULL;
      r.handle = '0;
      n = active_cells();
      if (want == 0 || want > n || last_handle >= HANDLE_LIMIT) return r;
      run = 0;
      for (i = 0; i < n; i++) begin
        run = (owner[i] == '0) ? run + 1 : 0;
        if (run == want) begin
          last_handle = last_handle + 1'b1;
          for (j = i + 1 - int'(want); j <= i; j++) owner[j] = last_handle;
          r.status = ST_OK;
          r.handle = last_handle;
          return r;
        end
      end
      return r;
    endfunction

    function result_t free_owner(logic [HANDLE_W-1:0] h);
      result_t r;
      int i, n;
      bit hit;
      r.status = ST_ERR;
      r.handle = '0;
      hit = 1'b0;
      n = active_cells();
      if (h == '0) return r;
      for (i = 0; i < n; i++) begin
        if (owner[i] == h) begin
          owner[i] = '0;
          hit = 1'b1;
        end
      end
      if (hit) r.status = ST_OK;
      return r;
    endfunction

    function result_t compact_map();
      result_t r;
      int rd, wr, n;
      n = active_cells();
      wr = 0;
      for (rd = 0; rd < n; rd++) begin
        if (owner[rd] != '0) begin
          owner[wr] = owner[rd];
          wr++;
        end
      end
      for (; wr < n; wr++) owner[wr] = '0;
      r.status = ST_OK;
      r.handle = '0;
      return r;
    endfunction

    function void note_command(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] arg);
      result_t r;
      case (op)
        OP_ALLOC: r = grant_run(arg);
        OP_ERASE: r = free_owner(arg);
        default: begin
          r = compact_map();
          n_compact++;
        end
      endcase
      n_cmds++;
      if (op == OP_ALLOC && r.status == ST_OK) n_grant++;
      if (r.status == ST_NULL) n_null++;
      if (r.status == ST_ERR) n_reject++;
      owed.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [HANDLE_W-1:0] handle);
      result_t want;
      n_checked++;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result word: status %0d handle %0d",
                   $time, status, handle);
      end else begin
        want = owed.pop_front();
        if (status !== want.status || handle !== want.handle) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch: expected status %0d handle %0d, got status %0d handle %0d",
                     $time, want.status, want.handle, status, handle);
        end
      end
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction

    function logic [HANDLE_W-1:0] pick_live();
      logic [HANDLE_W-1:0] seen [$];
      int i, n;
      n = active_cells();
      for (i = 0; i < n; i++)
        if (owner[i] != '0) seen.push_back(owner[i]);
      if (seen.size() == 0) return '0;
      return seen[$urandom_range(0, seen.size() - 1)];
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     opcode = OP_ALLOC;
  logic [HANDLE_W-1:0] size_or_handle = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] handle;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [POOL_W-1:0]   cfg_pool_cells = '0;

  bit no_idle = 1'b0;
  cell_map_tracker pool_map = new();

  first_fit_cell_allocator u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .opcode_i         (opcode),
    .size_or_handle_i (size_or_handle),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .status_o         (status),
    .handle_o         (handle),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_pool_cells_i (cfg_pool_cells)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : int'($urandom_range(0, 14));
  endfunction

  // called at a falling edge; valid is left high for a back-to-back word
  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [HANDLE_W-1:0] arg);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       = 1'b1;
    opcode         = op;
    size_or_handle = arg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pool_map.note_command(op, arg);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pool_map.pending() != 0) @(negedge clk);
  endtask

  task automatic write_pool(input logic [POOL_W-1:0] cells);
    wait_drained();
    cfg_valid      = 1'b1;
    cfg_pool_cells = cells;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    pool_map.pool_cells = cells;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_command();
    int unsigned n, roll, pick;
    logic [OP_W-1:0]     op;
    logic [HANDLE_W-1:0] arg;
    n    = pool_map.active_cells();
    roll = $urandom_range(0, 99);
    pick = $urandom_range(0, 9);
    if (roll < 45) begin
      op = OP_ALLOC;
      if (n == 0 || pick == 9) arg = HANDLE_W'($urandom);
      else if (pick < 7)       arg = HANDLE_W'($urandom_range(1, (n + 3) / 4));
      else                     arg = HANDLE_W'($urandom_range(1, n));
    end else if (roll < 80) begin
      op  = OP_ERASE;
      arg = pool_map.pick_live();
    end else if (roll < 90) begin
      op  = (pick < 3) ? OP_SPARE : OP_DEFRAG;
      arg = HANDLE_W'($urandom);
    end else begin
      op = OP_ERASE;
      case (pick % 4)
        0:       arg = '0;
        1:       arg = HANDLE_W'($urandom);
        2:       arg = pool_map.last_handle;
        default: arg = pool_map.last_handle + 1'b1;
      endcase
    end
    send_cmd(op, arg);
  endtask

  initial begin : result_sink
    int gap;
    @(posedge rst_n);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_stall = 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall = 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      pool_map.check_result(status, handle);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        stuck = 0;
      else
        stuck++;
    end
    $display("first_fit_cell_allocator_tb: errors");
    $finish;
  end

  initial begin : stimulus
    int p, k;
    logic [POOL_W-1:0] cells;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset pool of 128 cells
    send_cmd(OP_ALLOC, 16'd0);
    send_cmd(OP_ALLOC, 16'd129);
    send_cmd(OP_ALLOC, 16'hFFFF);
    send_cmd(OP_ALLOC, 16'd128);
    send_cmd(OP_ALLOC, 16'd1);
    send_cmd(OP_ERASE, 16'd0);
    send_cmd(OP_ERASE, 16'h5555);
    send_cmd(OP_ERASE, 16'd1);
    send_cmd(OP_ALLOC, 16'd1);
    send_cmd(OP_ALLOC, 16'd3);
    send_cmd(OP_ALLOC, 16'd2);
    send_cmd(OP_ERASE, 16'd3);
    send_cmd(OP_ALLOC, 16'd2);
    send_cmd(OP_ALLOC, 16'd4);
    send_cmd(OP_DEFRAG, 16'hAAAA);
    send_cmd(OP_ERASE, 16'd2);
    send_cmd(OP_SPARE, 16'h0000);
    send_cmd(OP_ERASE, 16'hFFFF);
    send_cmd(OP_ALLOC, 16'hAAAA);
    // empty pool, oversized setting clamped to the map size, then a one-cell pool
    write_pool(8'd0);
    send_cmd(OP_ALLOC, 16'd1);
    send_cmd(OP_ERASE, 16'd4);
    send_cmd(OP_DEFRAG, 16'd0);
    write_pool(8'd255);
    send_cmd(OP_ALLOC, 16'd120);
    write_pool(8'd1);
    send_cmd(OP_ALLOC, 16'd1);
    send_cmd(OP_ERASE, pool_map.owner[0]);

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0:       cells = 8'd128;
        1:       cells = 8'd1;
        2:       cells = 8'd255;
        3:       cells = 8'd2;
        6:       cells = 8'd128;
        default: cells = POOL_W'($urandom_range(3, 127));
      endcase
      write_pool(cells);
      for (k = 0; k < PHASE_WORDS; k++) begin
        if (k % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 59) == 0) wait_drained();
        random_command();
      end
    end

    // one-cell pool, back to back, then the full map again
    no_idle = 1'b1;
    write_pool(8'd1);
    if (pool_map.owner[0] != '0) send_cmd(OP_ERASE, pool_map.owner[0]);
    send_cmd(OP_ALLOC, 16'd1);
    send_cmd(OP_ALLOC, 16'd1);
    send_cmd(OP_ALLOC, 16'd0);
    send_cmd(OP_ERASE, pool_map.last_handle);
    send_cmd(OP_ERASE, HANDLE_LIMIT);
    no_idle = 1'b0;
    write_pool(8'd128);
    send_cmd(OP_ALLOC, 16'd1);
    send_cmd(OP_DEFRAG, 16'd0);

    wait_drained();
    repeat (SETTLE) @(negedge clk);

    $display("summary: %0d commands, %0d grants, %0d null, %0d rejected erases, %0d compactions",
             pool_map.n_cmds, pool_map.n_grant, pool_map.n_null, pool_map.n_reject,
             pool_map.n_compact);
    $display("summary: %0d result words checked, %0d mismatches, pools 0/1/2/128/255 and random, handles to %0d",
             pool_map.n_checked, pool_map.mismatches, pool_map.last_handle);
    if (pool_map.mismatches == 0 && pool_map.pending() == 0) begin
      $display("first_fit_cell_allocator_tb: clean");
    end else begin
      $display("first_fit_cell_allocator_tb: errors");
    end
    $finish;
  end

endmodule
